FILE: design/lmim_pkg.sv
// Package for the LED matrix index map: beat types, field widths, codes
// and default table limits. Used by led_matrix_index_map.
// No dependencies.
package lmim_pkg;

  localparam int KIND_W   = 2;
  localparam int COORD_W  = 6;
  localparam int INDEX_W  = 12;
  localparam int STATUS_W = 2;
  localparam int DIM_W    = 7;
  localparam int CFG_IDX_W = 2;

  localparam int MAX_COLUMNS_DEF = 64;
  localparam int MAX_ROWS_DEF    = 64;

  localparam logic [DIM_W-1:0] COLUMNS_RST = 7'd8;
  localparam logic [DIM_W-1:0] ROWS_RST    = 7'd8;

  localparam logic [KIND_W-1:0] KIND_BUILD  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_MIRROR = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ROTATE = 2'd2;
  localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd3;

  localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_RANGE     = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_NON_SQ    = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_NOT_BUILT = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WIRING  = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
  } in_beat_t;

  typedef struct packed {
    logic [INDEX_W-1:0]  strip_index;
    logic [STATUS_W-1:0] status;
  } out_beat_t;

endpackage

FILE: design/led_matrix_index_map.sv
// LED matrix index map top level: coordinate table, sequencer and config.
// Depends on lmim_pkg for beat types, codes and defaults.
//
// A small sequencer walks the active columns x rows region one entry at a
// time and forms strip values from a running row base and the column.
// Each table is a one-write, one-read memory with registered read data.
// A lookup goes via S_LOOK; a build writes each entry in S_BUILD; a mirror
// or rotate alternates S_MRD and S_MWR (a read and a write per entry into
// scratch), then S_CRD and S_CWR to copy back. Error statuses go straight
// to S_DONE. The block accepts one beat at a time; a finished result waits
// in an output register. The tables need no clearing after reset: nothing
// reads them before the first build.
module led_matrix_index_map #(
  parameter int MAX_COLUMNS = lmim_pkg::MAX_COLUMNS_DEF,
  parameter int MAX_ROWS    = lmim_pkg::MAX_ROWS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  lmim_pkg::in_beat_t             in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output lmim_pkg::out_beat_t            out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [lmim_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lmim_pkg::DIM_W-1:0]     cfg_data
);

  localparam int DEPTH = MAX_COLUMNS * MAX_ROWS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int XW    = $clog2(MAX_COLUMNS + 1);
  localparam int YW    = $clog2(MAX_ROWS + 1);
  localparam int CW    = (XW > YW) ? XW : YW;
  localparam int CMPW  = 10;
  localparam int IW    = lmim_pkg::INDEX_W;

  typedef enum logic [2:0] {
    S_IDLE, S_BUILD, S_MRD, S_MWR, S_CRD, S_CWR, S_LOOK, S_DONE
  } state_t;

  state_t               state_r, state_nxt;
  logic [lmim_pkg::DIM_W-1:0] cols_r, rows_r;
  logic                 wiring_r;
  logic                 built_r, built_nxt;
  logic                 is_rot_r, is_rot_nxt;
  logic [CW-1:0]        x_r, x_nxt, y_r, y_nxt;
  logic [IW-1:0]        vbase_r, vbase_nxt;
  lmim_pkg::out_beat_t  pend_r, pend_nxt;
  logic                 out_valid_r, out_valid_nxt;
  lmim_pkg::out_beat_t  out_data_r, out_data_nxt;

  logic [IW-1:0] idx_mem [DEPTH];
  logic [IW-1:0] scr_mem [DEPTH];
  logic [IW-1:0] idx_q_r, scr_q_r;

  logic [CW-1:0] eff_w, eff_h, pass_h;
  logic          last_x, last_y;
  logic          idx_we, scr_we;
  logic [AW-1:0] cur_addr, idx_rd_addr, scr_wr_addr;
  logic [IW-1:0] build_val, idx_wd;
  logic          lk_range;

  function automatic logic [AW-1:0] addr_of(input logic [CW-1:0] x, input logic [CW-1:0] y);
    logic [31:0] a;
    a = 32'(y) * 32'(MAX_COLUMNS) + 32'(x);
    return a[AW-1:0];
  endfunction

  always_comb begin
    if (cols_r == '0) begin
      eff_w = CW'(1);
    end else if (CMPW'(cols_r) > CMPW'(MAX_COLUMNS)) begin
      eff_w = CW'(MAX_COLUMNS);
    end else begin
      eff_w = CW'(cols_r);
    end
    if (rows_r == '0) begin
      eff_h = CW'(1);
    end else if (CMPW'(rows_r) > CMPW'(MAX_ROWS)) begin
      eff_h = CW'(MAX_ROWS);
    end else begin
      eff_h = CW'(rows_r);
    end
  end

  assign pass_h   = is_rot_r ? eff_w : eff_h;
  assign last_x   = (x_r == eff_w - CW'(1));
  assign last_y   = (y_r == pass_h - CW'(1));
  assign cur_addr = addr_of(x_r, y_r);
  assign lk_range = (CMPW'(in_data.col) >= CMPW'(eff_w)) ||
                    (CMPW'(in_data.row) >= CMPW'(eff_h));

  assign build_val = (wiring_r && y_r[0]) ?
                     IW'(vbase_r + IW'(eff_w) - IW'(1) - IW'(x_r)) :
                     IW'(vbase_r + IW'(x_r));
  assign idx_wd      = (state_r == S_BUILD) ? build_val : scr_q_r;
  assign idx_we      = (state_r == S_BUILD) || (state_r == S_CWR);
  assign scr_we      = (state_r == S_MWR);
  assign idx_rd_addr = (state_r == S_IDLE) ?
                       addr_of(CW'(in_data.col), CW'(in_data.row)) : cur_addr;
  assign scr_wr_addr = is_rot_r ? addr_of(eff_w - CW'(1) - y_r, x_r) :
                                  addr_of(eff_w - CW'(1) - x_r, y_r);

  always_ff @(posedge clk) begin
    if (idx_we) begin
      idx_mem[cur_addr] <= idx_wd;
    end
    idx_q_r <= idx_mem[idx_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (scr_we) begin
      scr_mem[scr_wr_addr] <= idx_q_r;
    end
    scr_q_r <= scr_mem[cur_addr];
  end

  always_comb begin
    state_nxt     = state_r;
    built_nxt     = built_r;
    is_rot_nxt    = is_rot_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    vbase_nxt     = vbase_r;
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (state_r == S_BUILD || state_r == S_MWR || state_r == S_CWR) begin
      if (last_x) begin
        x_nxt     = '0;
        y_nxt     = y_r + CW'(1);
        vbase_nxt = IW'(vbase_r + IW'(eff_w));
      end else begin
        x_nxt = x_r + CW'(1);
      end
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          x_nxt     = '0;
          y_nxt     = '0;
          vbase_nxt = '0;
          pend_nxt  = '0;
          case (in_data.kind)
            lmim_pkg::KIND_BUILD: begin
              is_rot_nxt = 1'b0;
              state_nxt  = S_BUILD;
            end
            lmim_pkg::KIND_MIRROR: begin
              is_rot_nxt = 1'b0;
              if (!built_r) begin
                pend_nxt.status = lmim_pkg::STAT_NOT_BUILT;
                state_nxt       = S_DONE;
              end else begin
                state_nxt = S_MRD;
              end
            end
            lmim_pkg::KIND_ROTATE: begin
              is_rot_nxt = 1'b1;
              if (!built_r) begin
                pend_nxt.status = lmim_pkg::STAT_NOT_BUILT;
                state_nxt       = S_DONE;
              end else if (eff_w != eff_h) begin
                pend_nxt.status = lmim_pkg::STAT_NON_SQ;
                state_nxt       = S_DONE;
              end else begin
                state_nxt = S_MRD;
              end
            end
            default: begin
              if (!built_r) begin
                pend_nxt.status = lmim_pkg::STAT_NOT_BUILT;
                state_nxt       = S_DONE;
              end else if (lk_range) begin
                pend_nxt.status = lmim_pkg::STAT_RANGE;
                state_nxt       = S_DONE;
              end else begin
                state_nxt = S_LOOK;
              end
            end
          endcase
        end
      end
      S_BUILD: begin
        if (last_x && last_y) begin
          built_nxt = 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_MRD: begin
        state_nxt = S_MWR;
      end
      S_MWR: begin
        if (last_x && last_y) begin
          x_nxt     = '0;
          y_nxt     = '0;
          state_nxt = S_CRD;
        end else begin
          state_nxt = S_MRD;
        end
      end
      S_CRD: begin
        state_nxt = S_CWR;
      end
      S_CWR: begin
        state_nxt = (last_x && last_y) ? S_DONE : S_CRD;
      end
      S_LOOK: begin
        pend_nxt.strip_index = idx_q_r;
        state_nxt            = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = pend_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      built_r     <= 1'b0;
      out_valid_r <= 1'b0;
      cols_r      <= lmim_pkg::COLUMNS_RST;
      rows_r      <= lmim_pkg::ROWS_RST;
      wiring_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      built_r     <= built_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          lmim_pkg::CFG_COLUMNS: cols_r   <= cfg_data;
          lmim_pkg::CFG_ROWS:    rows_r   <= cfg_data;
          lmim_pkg::CFG_WIRING:  wiring_r <= cfg_data[0];
          default: begin
          end
        endcase
      end
    end
    is_rot_r   <= is_rot_nxt;
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    vbase_r    <= vbase_nxt;
    pend_r     <= pend_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// Testbench for led_matrix_index_map: directed and random table commands with
// a cycle-free predictor of the coordinate-to-strip table, random idling on both sides.
// Depends on lmim_pkg and the led_matrix_index_map RTL.
module testbench;
  import lmim_pkg::*;

  localparam int TBL_DEPTH = MAX_COLUMNS_DEF * MAX_ROWS_DEF;
  localparam int PHASES = 16;
  localparam int PHASE_BEATS = 125;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  in_beat_t             in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_beat_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_COLUMNS;
  logic [DIM_W-1:0]     cfg_data = '0;

  in_beat_t  cmd_q[$];
  out_beat_t strip_q[$];
  int        beats_in = 0;
  int        beats_out = 0;
  int        err_cnt = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  int        bulky_ops = 0;

  logic [DIM_W-1:0]   set_cols = COLUMNS_RST;
  logic [DIM_W-1:0]   set_rows = ROWS_RST;
  logic               set_wiring = 1'b0;
  logic [INDEX_W-1:0] strip_map [TBL_DEPTH];
  logic [INDEX_W-1:0] strip_scratch [TBL_DEPTH];
  logic               map_built = 1'b0;
  bit                 ever_written [TBL_DEPTH];
  bit                 gen_built = 1'b0;

  led_matrix_index_map uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int clamp_dim(logic [DIM_W-1:0] d, int lim);
    if (d == 0) return 1;
    if (d > lim) return lim;
    return d;
  endfunction

  function automatic int tbl_addr(int x, int y);
    return y * MAX_COLUMNS_DEF + x;
  endfunction

  function automatic void copy_scratch(int w, int h);
    for (int y = 0; y < h; y++)
      for (int x = 0; x < w; x++)
        strip_map[tbl_addr(x, y)] = strip_scratch[tbl_addr(x, y)];
  endfunction

  function automatic out_beat_t map_predict(in_beat_t b);
    out_beat_t r;
    int        w;
    int        h;
    int        v;
    w = clamp_dim(set_cols, MAX_COLUMNS_DEF);
    h = clamp_dim(set_rows, MAX_ROWS_DEF);
    r.strip_index = '0;
    r.status = STAT_OK;
    if (b.kind == KIND_BUILD) begin
      for (int y = 0; y < h; y++) begin
        for (int x = 0; x < w; x++) begin
          v = (set_wiring && y[0]) ? (y + 1) * w - 1 - x : y * w + x;
          strip_map[tbl_addr(x, y)] = v[INDEX_W-1:0];
        end
      end
      map_built = 1'b1;
    end else if (!map_built) begin
      r.status = STAT_NOT_BUILT;
    end else if (b.kind == KIND_MIRROR) begin
      for (int y = 0; y < h; y++)
        for (int x = 0; x < w; x++)
          strip_scratch[tbl_addr(w - 1 - x, y)] = strip_map[tbl_addr(x, y)];
      copy_scratch(w, h);
    end else if (b.kind == KIND_ROTATE) begin
      if (w != h) begin
        r.status = STAT_NON_SQ;
      end else begin
        for (int y = 0; y < w; y++)
          for (int x = 0; x < w; x++)
            strip_scratch[tbl_addr(w - 1 - y, x)] = strip_map[tbl_addr(x, y)];
        copy_scratch(w, w);
      end
    end else if (b.col >= w || b.row >= h) begin
      r.status = STAT_RANGE;
    end else begin
      r.strip_index = strip_map[tbl_addr(b.col, b.row)];
    end
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    err_cnt++;
    if (err_cnt <= 200) $display("%0t MISMATCH: %s", $time, msg);
  endtask

  // driver: advance to the next pending beat once the current one is taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) strip_q.push_back(map_predict(in_data));
      if (cmd_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_data <= cmd_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : monitor
    out_beat_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        beats_out++;
        if (strip_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result beat %h", out_data));
        end else begin
          want = strip_q.pop_front();
          if (out_data.strip_index !== want.strip_index)
            report_mismatch($sformatf("strip_index got %0d want %0d",
                                      out_data.strip_index, want.strip_index));
          if (out_data.status !== want.status)
            report_mismatch($sformatf("status got %0d want %0d",
                                      out_data.status, want.status));
        end
      end
      out_ready <= $urandom_range(0, 99) >= recv_stall_pct;
    end
  end

  task automatic set_idling(int mode);
    case (mode)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
      default: begin send_idle_pct = 35; recv_stall_pct = 35; end
    endcase
  endtask

  task automatic wait_drained();
    while (beats_out < beats_in) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_COLUMNS: set_cols = val;
      CFG_ROWS:    set_rows = val;
      default:     set_wiring = val[0];
    endcase
    @(posedge clk);
  endtask

  task automatic push_cmd(logic [KIND_W-1:0] kind, int col, int row);
    in_beat_t b;
    int       w;
    int       h;
    w = clamp_dim(set_cols, MAX_COLUMNS_DEF);
    h = clamp_dim(set_rows, MAX_ROWS_DEF);
    b.kind = kind;
    b.col = col[COORD_W-1:0];
    b.row = row[COORD_W-1:0];
    if (kind == KIND_BUILD) begin
      for (int y = 0; y < h; y++)
        for (int x = 0; x < w; x++)
          ever_written[tbl_addr(x, y)] = 1'b1;
      gen_built = 1'b1;
    end
    cmd_q.push_back(b);
    beats_in++;
  endtask

  task automatic push_random();
    logic [KIND_W-1:0] kind;
    int                w;
    int                h;
    int                pick;
    int                x;
    int                y;
    bit                bulky;
    w = clamp_dim(set_cols, MAX_COLUMNS_DEF);
    h = clamp_dim(set_rows, MAX_ROWS_DEF);
    bulky = (w * h > 256);
    pick = $urandom_range(0, 99);
    x = $urandom_range(0, 63);
    y = $urandom_range(0, 63);
    kind = KIND_LOOKUP;
    if (!bulky || bulky_ops < 3) begin
      if (pick < (bulky ? 1 : 8)) kind = KIND_BUILD;
      else if (pick < (bulky ? 2 : 18)) kind = KIND_MIRROR;
      else if (pick < (bulky ? 3 : 28)) kind = KIND_ROTATE;
    end
    if (kind != KIND_LOOKUP && bulky) bulky_ops++;
    if (kind == KIND_LOOKUP && $urandom_range(0, 4) != 0) begin
      x = $urandom_range(0, w - 1);
      y = $urandom_range(0, h - 1);
    end
    // hold off reads of entries that no build has reached yet
    if (gen_built) begin
      if (kind == KIND_MIRROR && !ever_written[tbl_addr(w - 1, h - 1)])
        kind = KIND_BUILD;
      if (kind == KIND_ROTATE && w == h && !ever_written[tbl_addr(w - 1, h - 1)])
        kind = KIND_BUILD;
      if (kind == KIND_LOOKUP && x < w && y < h && !ever_written[tbl_addr(x, y)])
        kind = KIND_BUILD;
    end
    push_cmd(kind, x, y);
  endtask

  function automatic logic [DIM_W-1:0] pick_dim();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return DIM_W'($urandom_range(65, 127));
    if (r == 2) return DIM_W'(MAX_COLUMNS_DEF);
    if (r <= 6) return DIM_W'($urandom_range(9, 32));
    return DIM_W'($urandom_range(1, 8));
  endfunction

  initial begin
    logic [DIM_W-1:0] c;
    logic [DIM_W-1:0] r;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    set_idling(0);

    push_cmd(KIND_LOOKUP, 0, 0);
    push_cmd(KIND_MIRROR, 0, 0);
    push_cmd(KIND_ROTATE, 0, 0);
    push_cmd(KIND_BUILD, 63, 63);
    push_cmd(KIND_LOOKUP, 7, 7);
    push_cmd(KIND_LOOKUP, 8, 0);
    push_cmd(KIND_LOOKUP, 63, 63);
    push_cmd(KIND_MIRROR, 63, 63);
    push_cmd(KIND_LOOKUP, 7, 3);
    push_cmd(KIND_ROTATE, 0, 0);
    push_cmd(KIND_LOOKUP, 7, 0);
    wait_drained();

    // shrink without a rebuild, then serpentine build
    cfg_write(CFG_COLUMNS, 7'd5);
    cfg_write(CFG_ROWS, 7'd3);
    cfg_write(CFG_WIRING, 7'd1);
    push_cmd(KIND_LOOKUP, 4, 2);
    push_cmd(KIND_LOOKUP, 5, 0);
    push_cmd(KIND_ROTATE, 0, 0);
    push_cmd(KIND_BUILD, 0, 0);
    push_cmd(KIND_LOOKUP, 4, 1);
    wait_drained();

    cfg_write(CFG_COLUMNS, 7'd64);
    cfg_write(CFG_ROWS, 7'd64);
    push_cmd(KIND_BUILD, 0, 0);
    push_cmd(KIND_ROTATE, 0, 0);
    push_cmd(KIND_MIRROR, 0, 0);
    push_cmd(KIND_LOOKUP, 63, 63);
    wait_drained();

    cfg_write(CFG_COLUMNS, 7'd0);
    cfg_write(CFG_ROWS, 7'd127);
    cfg_write(CFG_WIRING, 7'd0);
    push_cmd(KIND_ROTATE, 0, 0);
    push_cmd(KIND_LOOKUP, 0, 63);
    push_cmd(KIND_MIRROR, 0, 0);
    wait_drained();

    cfg_write(CFG_COLUMNS, 7'd127);
    cfg_write(CFG_ROWS, 7'd0);
    push_cmd(KIND_LOOKUP, 63, 0);
    push_cmd(KIND_LOOKUP, 0, 1);

    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      set_idling(p % 4);
      c = pick_dim();
      r = ($urandom_range(0, 9) < 3) ? c : pick_dim();
      cfg_write(CFG_COLUMNS, c);
      cfg_write(CFG_ROWS, r);
      cfg_write(CFG_WIRING, DIM_W'($urandom_range(0, 1)));
      bulky_ops = 0;
      repeat (PHASE_BEATS) push_random();
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (strip_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", strip_q.size()));
    if (err_cnt == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("testbench: done, errors");
    $finish;
  end

endmodule

FILE: files.f
design/lmim_pkg.sv
design/led_matrix_index_map.sv
tb/testbench.sv
